>>> design/pcw_pkg.sv
`default_nettype none
package pcw_pkg;

	// request codes as they arrive on req_type
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [2:0] ST_COMPLETE  = 3'd0;
	localparam logic [2:0] ST_MISSING   = 3'd1;
	localparam logic [2:0] ST_NO_MOTHER = 3'd2;
	localparam logic [2:0] ST_CYCLE     = 3'd3;
	localparam logic [2:0] ST_DUP       = 3'd4;
	localparam logic [2:0] ST_DEPTH     = 3'd5;

	localparam int ID_W  = 32;
	// table word: {duplicate, id, mother}
	localparam int ENT_W = 2 * ID_W + 1;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [ID_W-1:0]  mother;
		logic [ID_W-1:0]  anc;
	} item_t;

endpackage
`default_nettype wire

>>> design/pcw_ram.sv
`default_nettype none
module pcw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> design/pcw_front.sv
`default_nettype none
module pcw_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    req_type,
	input  wire logic [31:0]   track_id,
	input  wire logic [31:0]   mother_track_id,
	input  wire logic [31:0]   ancestor_track_id,
	output logic               q_valid,
	output pcw_pkg::item_t     q_item,
	input  wire logic          q_pop
);
	import pcw_pkg::*;

	// two-entry request queue; unused codes are dropped on entry
	item_t       slot_q [2];
	logic        wptr_q, rptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	op_t         op_in;

	assign op_in    = op_t'(req_type);
	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && (op_in != OP_NONE);
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= '{op: op_in, id: track_id, mother: mother_track_id,
				anc: ancestor_track_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/pcw_back.sv
`default_nettype none
module pcw_back #(
	parameter int TABLE_ENTRIES = 256,
	parameter int CHAIN_DEPTH   = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [6:0]    steps,
	input  wire logic          q_valid,
	input  wire pcw_pkg::item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        visited_id,
	output logic               id_valid,
	output logic               last,
	output logic [2:0]         walk_status,
	output logic               has_ancestor,
	output logic               table_overflow
);
	import pcw_pkg::*;

	localparam int TAW = $clog2(TABLE_ENTRIES);
	localparam int TW  = $clog2(TABLE_ENTRIES + 1);
	localparam int CAW = $clog2(CHAIN_DEPTH);
	localparam int CW  = $clog2(CHAIN_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_TSCAN = 5'b00010,
		S_CSCAN = 5'b00100,
		S_EMRD  = 5'b01000,
		S_EMWR  = 5'b10000
	} st_t;

	typedef enum logic [1:0] {
		PUR_LOAD  = 2'd0,
		PUR_START = 2'd1,
		PUR_MDUP  = 2'd2
	} pur_t;

	st_t              state_q;
	pur_t             pur_q;
	logic [ID_W-1:0]  key_q, mother_in_q, anc_id_q, ent_mother_q;
	logic [TW-1:0]    tidx_q, cnt_q;
	logic [TAW-1:0]   tra_q;
	logic             trv_q, ovf_q;
	logic [CW-1:0]    cidx_q, n_q;
	logic             crv_q, anc_q;
	logic [6:0]       depth_q;
	logic [2:0]       stat_q;

	logic             t_we, t_re, c_we, c_re;
	logic [TAW-1:0]   t_waddr;
	logic [ENT_W-1:0] t_wdata, trd;
	logic [CAW-1:0]   c_raddr;
	logic [ID_W-1:0]  crd;
	logic             thit, tmore, tdup, chit, cmore, room, out_free, em_last;

	assign thit     = trv_q && (trd[2*ID_W-1:ID_W] == key_q);
	assign tdup     = trd[ENT_W-1];
	assign tmore    = (tidx_q < cnt_q);
	assign room     = (cnt_q < TW'(TABLE_ENTRIES));
	assign chit     = crv_q && (crd == key_q);
	assign cmore    = (cidx_q < n_q);
	assign out_free = !out_valid || out_ready;
	assign em_last  = ((cidx_q + CW'(1)) == n_q);
	assign q_pop    = (state_q == S_IDLE);

	always_comb begin
		t_re    = (state_q == S_TSCAN) && !thit && tmore;
		t_we    = 1'b0;
		t_waddr = tra_q;
		t_wdata = {1'b1, trd[2*ID_W-1:0]};
		if ((state_q == S_TSCAN) && (pur_q == PUR_LOAD)) begin
			if (thit) begin
				t_we = 1'b1;
			end else if (!tmore && room) begin
				t_we    = 1'b1;
				t_waddr = cnt_q[TAW-1:0];
				t_wdata = {1'b0, key_q, mother_in_q};
			end
		end
		c_re    = 1'b0;
		c_raddr = cidx_q[CAW-1:0];
		c_we    = (state_q == S_CSCAN) && !chit && !cmore;
		if (state_q == S_CSCAN) c_re = !chit && cmore;
		if (state_q == S_EMRD)  c_re = (n_q != '0);
	end

	pcw_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(tidx_q[TAW-1:0]), .rdata(trd)
	);

	pcw_ram #(.WIDTH(ID_W), .DEPTH(CHAIN_DEPTH)) u_chain (
		.clk(clk), .we(c_we), .waddr(n_q[CAW-1:0]), .wdata(key_q),
		.re(c_re), .raddr(c_raddr), .rdata(crd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
			trv_q     <= 1'b0;
			crv_q     <= 1'b0;
		end else begin
			// result taken; the emit state reloads the register itself
			if (out_valid && out_ready && (state_q != S_EMWR)) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						key_q       <= q_item.id;
						mother_in_q <= q_item.mother;
						anc_id_q    <= q_item.anc;
						tidx_q      <= '0;
						trv_q       <= 1'b0;
						n_q         <= '0;
						depth_q     <= '0;
						anc_q       <= 1'b0;
						case (q_item.op)
							OP_LOAD: begin
								pur_q   <= PUR_LOAD;
								state_q <= S_TSCAN;
							end
							OP_QUERY: begin
								pur_q   <= PUR_START;
								state_q <= S_TSCAN;
							end
							OP_CLEAR: begin
								cnt_q <= '0;
								ovf_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_TSCAN: begin
					if (!thit && tmore) begin
						tidx_q <= tidx_q + TW'(1);
						tra_q  <= tidx_q[TAW-1:0];
						trv_q  <= 1'b1;
					end else begin
						trv_q  <= 1'b0;
						cidx_q <= '0;
						crv_q  <= 1'b0;
						ent_mother_q <= trd[ID_W-1:0];
						case (pur_q)
							PUR_LOAD: begin
								if (!thit) begin
									if (room) cnt_q <= cnt_q + TW'(1);
									else      ovf_q <= 1'b1;
								end
								state_q <= S_IDLE;
							end
							PUR_START: begin
								if (thit && tdup) begin
									stat_q  <= ST_DUP;
									state_q <= S_EMRD;
								end else if (thit) begin
									state_q <= S_CSCAN;
								end else begin
									stat_q  <= ST_MISSING;
									state_q <= S_EMRD;
								end
							end
							default: begin
								if (thit && tdup) begin
									stat_q  <= ST_DUP;
									state_q <= S_EMRD;
								end else if ((depth_q + 7'd1) == steps) begin
									stat_q  <= ST_DEPTH;
									state_q <= S_EMRD;
								end else if (thit) begin
									depth_q <= depth_q + 7'd1;
									state_q <= S_CSCAN;
								end else begin
									stat_q  <= ST_NO_MOTHER;
									state_q <= S_EMRD;
								end
							end
						endcase
					end
				end
				S_CSCAN: begin
					if (chit) begin
						crv_q   <= 1'b0;
						cidx_q  <= '0;
						stat_q  <= ST_CYCLE;
						state_q <= S_EMRD;
					end else if (cmore) begin
						cidx_q <= cidx_q + CW'(1);
						crv_q  <= 1'b1;
					end else begin
						// append current id to the chain
						crv_q  <= 1'b0;
						cidx_q <= '0;
						n_q    <= n_q + CW'(1);
						if ((n_q != '0) && (key_q == anc_id_q)) anc_q <= 1'b1;
						if (ent_mother_q == '0) begin
							stat_q  <= ST_COMPLETE;
							state_q <= S_EMRD;
						end else begin
							key_q   <= ent_mother_q;
							pur_q   <= PUR_MDUP;
							tidx_q  <= '0;
							trv_q   <= 1'b0;
							state_q <= S_TSCAN;
						end
					end
				end
				S_EMRD: begin
					state_q <= S_EMWR;
				end
				S_EMWR: begin
					if (out_free) begin
						out_valid <= 1'b1;
						if (n_q == '0) begin
							visited_id     <= '0;
							id_valid       <= 1'b0;
							last           <= 1'b1;
							walk_status    <= stat_q;
							has_ancestor   <= 1'b0;
							table_overflow <= ovf_q;
							state_q        <= S_IDLE;
						end else begin
							visited_id     <= crd;
							id_valid       <= 1'b1;
							last           <= em_last;
							walk_status    <= em_last ? stat_q : ST_COMPLETE;
							has_ancestor   <= em_last && anc_q;
							table_overflow <= em_last && ovf_q;
							cidx_q         <= cidx_q + CW'(1);
							state_q        <= em_last ? S_IDLE : S_EMRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/parent_chain_walker_unit.sv
// Parent chain walker. Requests arrive on in_valid/in_ready: load (0) stores
// an (id, mother) record, query (1) walks mother links from track_id, clear (2)
// empties the table; code 3 is dropped. Loads and clears give no results; a
// query gives one result per visited id (start first), or a single result
// with id_valid low when the start id is missing or a duplicate. Status,
// has_ancestor and table_overflow are meaningful only with last. max_depth is
// written through cfg_wdata; the user is to write it only while the
// block is idle, which the block does not enforce. Values above CHAIN_DEPTH-2
// act as CHAIN_DEPTH-2. A two-entry queue takes requests while the walker
// works. The table is one RAM with a write and a read port, scanned linearly,
// one entry per cycle; a load scans the records held, each walk step scans the
// table and then the ids already visited, and each result is read in S_EMRD
// and sent in S_EMWR. No clearing pass is needed after reset or clear.
`default_nettype none
module parent_chain_walker_unit #(
	parameter int TABLE_ENTRIES = 256,
	parameter int CHAIN_DEPTH   = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [5:0]         cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [31:0] track_id,
	input  wire logic signed [31:0] mother_track_id,
	input  wire logic signed [31:0] ancestor_track_id,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      visited_id,
	output logic                    id_valid,
	output logic                    last,
	output logic [2:0]              walk_status,
	output logic                    has_ancestor,
	output logic                    table_overflow
);
	import pcw_pkg::*;

	// longest walk keeps CHAIN_DEPTH-1 ids
	localparam logic [6:0] CAP_MAX = 7'(CHAIN_DEPTH - 2);

	logic [5:0]  max_depth_q;
	logic [6:0]  cap, steps;
	logic        q_valid, q_pop;
	item_t       q_item;
	logic [31:0] vid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= 6'd62;
		end else if (cfg_we) begin
			max_depth_q <= cfg_wdata;
		end
	end

	assign cap   = ({1'b0, max_depth_q} > CAP_MAX) ? CAP_MAX : {1'b0, max_depth_q};
	assign steps = cap + 7'd1;

	// front: accept and classify requests
	pcw_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .track_id(track_id),
		.mother_track_id(mother_track_id), .ancestor_track_id(ancestor_track_id),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	// back: table updates, chain walk and result stream
	pcw_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .CHAIN_DEPTH(CHAIN_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .steps(steps),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.visited_id(vid), .id_valid(id_valid), .last(last),
		.walk_status(walk_status), .has_ancestor(has_ancestor),
		.table_overflow(table_overflow)
	);

	assign visited_id = vid;
endmodule
`default_nettype wire

>>> design/pcw_checker.sv
`default_nettype none
module pcw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] visited_id,
	input wire logic        id_valid,
	input wire logic        last,
	input wire logic [2:0]  walk_status,
	input wire logic        has_ancestor,
	input wire logic        table_overflow
);
	import pcw_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(visited_id) && $stable(last))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !id_valid |-> last && visited_id == '0 &&
			(walk_status == ST_MISSING || walk_status == ST_DUP))
		else $error("bad empty-chain result");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> walk_status == ST_COMPLETE && !has_ancestor &&
			!table_overflow && id_valid)
		else $error("status on non-final result");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> walk_status <= ST_DEPTH)
		else $error("walk status out of range");
endmodule

bind parent_chain_walker_unit pcw_checker u_pcw_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.visited_id(visited_id), .id_valid(id_valid), .last(last),
	.walk_status(walk_status), .has_ancestor(has_ancestor),
	.table_overflow(table_overflow)
);
`default_nettype wire

>>> sim/parent_chain_walker_unit_test.sv
`timescale 1ns / 1ps
module parent_chain_walker_unit_test;
	import pcw_pkg::*;

	localparam int TBL_N     = 256;
	localparam int CHAIN_N   = 64;
	// Longest quiet stretch: a deep walk on a full table (63 steps, each scanning
	// the table) plus a long receiver hold-off, taken several times over.
	localparam int STALL_LIMIT = 200000;
	// Loads make no results; up to three can still be in the pipe when the
	// last walk result shows up (queue of two plus one in the table scan).
	localparam int SETTLE_CYCLES = 1500;

	typedef struct packed {
		logic [31:0] vid;
		logic        vld;
		logic        lst;
		logic [2:0]  status;
		logic        anc;
		logic        ovf;
	} walk_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = OP_NONE;
	logic signed [31:0] track_id = '0;
	logic signed [31:0] mother_track_id = '0;
	logic signed [31:0] ancestor_track_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] visited_id;
	logic id_valid;
	logic last;
	logic [2:0] walk_status;
	logic has_ancestor;
	logic table_overflow;

	parent_chain_walker_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .track_id(track_id),
		.mother_track_id(mother_track_id), .ancestor_track_id(ancestor_track_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.visited_id(visited_id), .id_valid(id_valid), .last(last),
		.walk_status(walk_status), .has_ancestor(has_ancestor),
		.table_overflow(table_overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow copy of the particle table and the max_depth register
	// ---------------------------------------------------------------
	logic        tbl_valid [TBL_N];
	logic [31:0] tbl_id    [TBL_N];
	logic [31:0] tbl_mother[TBL_N];
	logic        tbl_dup   [TBL_N];
	int          tbl_count;
	logic        tbl_ovf;
	logic [5:0]  depth_reg;

	walk_res_t chain_q[$];     // walk results still owed by the block

	int errors = 0;
	int reqs_sent = 0;
	int results_seen = 0;
	int walks_sent = 0;
	bit idle_on = 1'b1;        // both sides insert random gaps when set
	int hold_req = 0;          // one-shot long receiver hold-off
	bit [5:0] status_seen = '0;

	function automatic int find_slot(logic [31:0] key);
		for (int i = 0; i < tbl_count && i < TBL_N; i++)
			if (tbl_valid[i] && tbl_id[i] == key)
				return i;
		return -1;
	endfunction

	function automatic bit is_dup(logic [31:0] key);
		int s;
		s = find_slot(key);
		return s >= 0 && tbl_dup[s];
	endfunction

	task automatic table_wipe();
		for (int i = 0; i < TBL_N; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_dup[i] = 1'b0;
		end
		tbl_count = 0;
		tbl_ovf = 1'b0;
	endtask

	// Apply one accepted request to the shadow table and queue any walk results.
	task automatic walk_predict(op_t op, logic [31:0] id, logic [31:0] mo,
	                            logic [31:0] anc_id);
		logic [31:0] path[CHAIN_N];
		logic [31:0] cur;
		logic [2:0]  st;
		logic        anc;
		int n, s, cap;
		bit seen;
		walk_res_t r;
		case (op)
			OP_LOAD: begin
				s = find_slot(id);
				if (s >= 0)
					tbl_dup[s] = 1'b1;
				else if (tbl_count < TBL_N) begin
					tbl_valid[tbl_count] = 1'b1;
					tbl_id[tbl_count] = id;
					tbl_mother[tbl_count] = mo;
					tbl_dup[tbl_count] = 1'b0;
					tbl_count++;
				end else
					tbl_ovf = 1'b1;
			end
			OP_CLEAR: table_wipe();
			OP_QUERY: begin
				n = 0;
				st = ST_DEPTH;
				cur = id;
				anc = 1'b0;
				cap = (depth_reg > CHAIN_N - 2) ? CHAIN_N - 2 : depth_reg;
				if (is_dup(id))
					st = ST_DUP;
				else begin
					for (int d = 0; d <= cap; d++) begin
						s = find_slot(cur);
						if (s < 0) begin
							st = (n == 0) ? ST_MISSING : ST_NO_MOTHER;
							break;
						end
						seen = 1'b0;
						for (int k = 0; k < n; k++)
							if (path[k] == cur)
								seen = 1'b1;
						if (seen) begin
							st = ST_CYCLE;
							break;
						end
						path[n] = cur;
						n++;
						if (tbl_mother[s] == 32'd0) begin
							st = ST_COMPLETE;
							break;
						end
						if (is_dup(tbl_mother[s])) begin
							st = ST_DUP;
							break;
						end
						cur = tbl_mother[s];
					end
				end
				for (int k = 1; k < n; k++)
					if (path[k] == anc_id)
						anc = 1'b1;
				status_seen[st] = 1'b1;
				walks_sent++;
				if (n == 0) begin
					r = '{vid: 32'd0, vld: 1'b0, lst: 1'b1, status: st, anc: 1'b0,
					      ovf: tbl_ovf};
					chain_q = {chain_q, r};
				end
				for (int k = 0; k < n; k++) begin
					if (k == n - 1)
						r = '{vid: path[k], vld: 1'b1, lst: 1'b1, status: st,
						      anc: anc, ovf: tbl_ovf};
					else
						r = '{vid: path[k], vld: 1'b1, lst: 1'b0, status: ST_COMPLETE,
						      anc: 1'b0, ovf: 1'b0};
					chain_q = {chain_q, r};
				end
			end
			default: ;  // unused code: dropped by the block
		endcase
	endtask

	// ---------------------------------------------------------------
	// Request side: one request per call, valid held until accepted
	// ---------------------------------------------------------------
	task automatic send_req(op_t op, logic [31:0] id, logic [31:0] mo,
	                        logic [31:0] anc_id);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		track_id <= id;
		mother_track_id <= mo;
		ancestor_track_id <= anc_id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		walk_predict(op, id, mo, anc_id);
		if (op != OP_NONE)
			reqs_sent++;
	endtask

	// Drop valid, let everything drain, then allow the loads left to finish.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chain_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_depth(logic [5:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		depth_reg = v;
	endtask

	// ---------------------------------------------------------------
	// Result side: random back-pressure and field-by-field compare
	// ---------------------------------------------------------------
	initial begin : result_check
		int stall;
		walk_res_t exp_r;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 13) : 0;
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			results_seen++;
			if (chain_q.size() == 0) begin
				$display("%0t: unexpected result id=%0d valid=%0b last=%0b", $time,
				         visited_id, id_valid, last);
				errors++;
			end else begin
				exp_r = chain_q.pop_front();
				if (visited_id !== exp_r.vid) begin
					$display("%0t: visited_id exp %0d got %0d", $time,
					         $signed(exp_r.vid), visited_id);
					errors++;
				end
				if (id_valid !== exp_r.vld) begin
					$display("%0t: id_valid exp %0b got %0b", $time, exp_r.vld, id_valid);
					errors++;
				end
				if (last !== exp_r.lst) begin
					$display("%0t: last exp %0b got %0b", $time, exp_r.lst, last);
					errors++;
				end
				if (walk_status !== exp_r.status) begin
					$display("%0t: walk_status exp %0d got %0d", $time, exp_r.status,
					         walk_status);
					errors++;
				end
				if (has_ancestor !== exp_r.anc) begin
					$display("%0t: has_ancestor exp %0b got %0b", $time, exp_r.anc,
					         has_ancestor);
					errors++;
				end
				if (table_overflow !== exp_r.ovf) begin
					$display("%0t: table_overflow exp %0b got %0b", $time, exp_r.ovf,
					         table_overflow);
					errors++;
				end
			end
		end
	end

	// Watchdog: quiet cycles on both channels
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Every status but the depth limit, the id extremes and the unused request code.
	task automatic test_walk_statuses();
		send_req(OP_CLEAR, 0, 0, 0);
		send_req(OP_LOAD, 10, 20, 0);
		send_req(OP_LOAD, 20, 30, 0);
		send_req(OP_LOAD, 30, 0, 0);
		send_req(OP_QUERY, 10, 0, 30);             // complete, ancestor found
		send_req(OP_QUERY, 10, 0, 10);             // start id never counts
		send_req(OP_QUERY, 99, 0, 0);              // start missing
		send_req(OP_LOAD, 40, 41, 0);
		send_req(OP_QUERY, 40, 0, 41);             // mother missing
		send_req(OP_LOAD, 50, 51, 0);
		send_req(OP_LOAD, 51, 50, 0);
		send_req(OP_QUERY, 50, 0, 51);             // loop back to start
		send_req(OP_LOAD, 60, 61, 0);
		send_req(OP_LOAD, 61, 0, 0);
		send_req(OP_LOAD, 61, 7, 0);               // second record: duplicate
		send_req(OP_QUERY, 60, 0, 61);             // stops at duplicate mother
		send_req(OP_QUERY, 61, 0, 0);              // duplicate start: empty chain
		send_req(OP_NONE, 10, 0, 30);              // ignored
		send_req(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_req(OP_LOAD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		send_req(OP_LOAD, 32'hFFFF_FFFF, 0, 32'h8000_0000);
		send_req(OP_QUERY, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(OP_QUERY, 0, 32'hFFFF_FFFF, 0);   // id zero is not loaded
		drain();
	endtask

	// Short chain against several depth settings, including 0 and 63.
	task automatic test_depth_limit();
		logic [5:0] depths[5];
		depths = '{6'd0, 6'd1, 6'd5, 6'd63, 6'd62};
		send_req(OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < 12; i++)
			send_req(OP_LOAD, 1000 + i, (i == 11) ? 0 : 1001 + i, 0);
		foreach (depths[d]) begin
			set_depth(depths[d]);
			send_req(OP_QUERY, 1000, 0, 1000 + depths[d]);
			send_req(OP_QUERY, 1004, 0, 1011);     // finishes only under depths 63 and 62
		end
		drain();
	endtask

	// Fill the table, overflow it, then check clear drops the sticky flag.
	task automatic test_full_table();
		idle_on = 1'b0;
		send_req(OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < TBL_N; i++)
			send_req(OP_LOAD, 5000 + i, (i == TBL_N - 1) ? 0 : 5001 + i, 0);
		send_req(OP_QUERY, 5250, 0, 5255);         // full but no overflow yet
		send_req(OP_LOAD, 9999, 0, 0);             // new id dropped
		send_req(OP_LOAD, 5255, 1, 0);             // present id still marked
		send_req(OP_QUERY, 5240, 0, 5250);
		send_req(OP_QUERY, 9999, 0, 0);
		send_req(OP_QUERY, 5000, 0, 5030);         // runs into the depth limit
		set_depth(6'd63);                          // clamps to the same limit
		send_req(OP_QUERY, 5000, 0, 5062);
		send_req(OP_CLEAR, 0, 0, 0);
		send_req(OP_QUERY, 5000, 0, 0);
		idle_on = 1'b1;
		drain();
	endtask

	// Random events: a clear, a burst of loads over a small id pool so that
	// links, loops and repeats are common, then queries; some noise mixed in.
	task automatic test_random_events();
		logic [31:0] pool[12];
		logic [31:0] mo;
		int nload, nq;
		bit held = 1'b0;
		while (reqs_sent < 340) begin
			if ($urandom_range(0, 3) == 0)
				set_depth(6'($urandom_range(0, 63)));
			idle_on = ($urandom_range(0, 3) != 0);
			foreach (pool[i])
				case ($urandom_range(0, 5))
					0: pool[i] = 32'h8000_0000 + $urandom_range(0, 3);
					1: pool[i] = 32'h7FFF_FFFF - $urandom_range(0, 3);
					default: pool[i] = $urandom;
				endcase
			send_req(OP_CLEAR, $urandom, $urandom, $urandom);
			nload = $urandom_range(2, 14);
			for (int i = 0; i < nload; i++) begin
				case ($urandom_range(0, 5))
					0: mo = 32'd0;
					1: mo = $urandom;
					2: mo = pool[$urandom_range(0, 11)];
					default: mo = pool[(i + 1) % 12];
				endcase
				send_req(OP_LOAD, pool[i % 12], mo, $urandom);
			end
			if (!held) begin
				hold_req = 3000;                   // let the input side back up
				held = 1'b1;
			end
			nq = $urandom_range(2, 6);
			for (int i = 0; i < nq; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_req($urandom_range(0, 1) ? OP_NONE : OP_QUERY, $urandom,
					         $urandom, $urandom);
				else
					send_req(OP_QUERY, pool[$urandom_range(0, 11)], $urandom,
					         pool[$urandom_range(0, 11)]);
			end
		end
		drain();
	endtask

	initial begin
		depth_reg = 6'd62;
		table_wipe();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_walk_statuses();
		test_depth_limit();
		test_full_table();
		test_random_events();
		$display("Sent %0d requests (%0d walks), checked %0d walk results.",
		         reqs_sent, walks_sent, results_seen);
		$display("Walk endings observed (bit per status): %b", status_seen);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
